// ===== sv/tppg_pkg.sv =====
// Shared types, constants and register indexes of the test pattern pixel generator.
`timescale 1ns / 1ps
package tppg_pkg;

   // Pattern geometry.
   localparam int unsigned BORDER_PIXELS = 20;
   localparam int unsigned MAX_DIMENSION = 4096;
   localparam int unsigned MIN_DIMENSION = 2 * BORDER_PIXELS + 1;

   // Depth of the queue between classification and output formatting.
   localparam int unsigned QUEUE_DEPTH = 4;

   // Register indexes on the configuration port (byte address / 4).
   localparam logic [2:0] REG_FRAME_WIDTH  = 3'd0;
   localparam logic [2:0] REG_FRAME_HEIGHT = 3'd1;
   localparam logic [2:0] REG_PIXEL_MODE   = 3'd2;
   localparam logic [2:0] REG_LINE_BYTES   = 3'd3;
   localparam logic [2:0] REG_FRAME_BASE   = 3'd4;

   // Full 24-bit colors of the pattern.
   localparam logic [23:0] COLOR_BLACK   = 24'h000000;
   localparam logic [23:0] COLOR_WHITE   = 24'hffffff;
   localparam logic [23:0] COLOR_BLUE    = 24'h0000ff;
   localparam logic [23:0] COLOR_GREEN   = 24'h00ff00;
   localparam logic [23:0] COLOR_RED     = 24'hff0000;
   localparam logic [23:0] COLOR_YELLOW  = 24'hffff00;
   localparam logic [23:0] COLOR_MAGENTA = 24'hff00ff;
   localparam logic [23:0] COLOR_CYAN    = 24'h00ffff;

   // Which part of the pattern a pixel falls in.
   typedef enum logic [3:0] {
      CLASS_BLACK,
      CLASS_WHITE,
      CLASS_BLUE,
      CLASS_GREEN,
      CLASS_RED,
      CLASS_YELLOW,
      CLASS_MAGENTA,
      CLASS_CYAN,
      CLASS_RAMP_BLUE,
      CLASS_RAMP_GREEN,
      CLASS_RAMP_RED
   } color_class_type;

   // Configuration as seen by the datapath.
   typedef struct packed {
      logic [12:0] frame_width;
      logic [12:0] frame_height;
      logic        pixel_mode;
      logic [14:0] line_bytes;
      logic [31:0] frame_base;
   } cfg_type;

   // Request and response payloads.
   typedef struct packed {
      logic [11:0] pixel_x;
      logic [11:0] pixel_y;
   } req_type;

   typedef struct packed {
      logic [23:0] pixel_word;
      logic [31:0] write_address;
      logic        in_range;
   } rsp_type;

   // One classified pixel waiting in the queue.
   typedef struct packed {
      color_class_type color_class;
      logic [7:0]      ramp_level;
      logic [11:0]     pixel_x;
      logic [26:0]     row_offset;
      logic            in_range;
   } entry_type;

endpackage

// ===== sv/test_pattern_pixel_generator.sv =====
// Top level of the test pattern pixel generator: register file, front end, queue, back end.
//
// Usage: each request transfer carries one pixel coordinate (pixel_x, pixel_y). Each
// accepted request yields exactly one response transfer, in order, with the pattern
// word to store (RGB565 or 0xRRGGBB), its byte address and in_range. Coordinates off
// the frame return in_range low with a zero word and a zero address.
// The request is registered in the queue and then formatted into the output register.
// Throughput: one pixel per clock while rsp_ready stays high, set by the combinational
// classify path and the format path.
// A four-entry queue sits between classification and formatting, so req_ready stays
// high while a response waits; it drops only after the queue fills during a stall.
// The output register holds its response stable until rsp_ready takes it.
// Configuration: APB registers at byte addresses 0x00 frame_width, 0x04
// frame_height, 0x08 pixel_mode, 0x0c line_bytes, 0x10 frame_base. Width and height
// are clamped into 41..4096 on write. Write them only while the block is idle.
// Reset (synchronous) empties the queue and the output register and loads the
// registers with 640 x 480, 32-bit pixels, 2560-byte lines and base address zero.
`timescale 1ns / 1ps
module test_pattern_pixel_generator (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  tppg_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output tppg_pkg::rsp_type rsp_payload,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [4:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);
   import tppg_pkg::*;

   localparam logic [12:0] DIM_LOW  = 13'(MIN_DIMENSION);
   localparam logic [12:0] DIM_HIGH = 13'(MAX_DIMENSION);

   cfg_type   cfg_ff;
   cfg_type   cfg_in;
   logic      cfg_write;
   logic      queue_full;
   logic      queue_push;
   logic      queue_pop;
   logic      head_valid;
   entry_type push_data;
   entry_type head_data;

   // Saturate a frame dimension into the legal range.
   function automatic logic [12:0] clamp_dim(input logic [31:0] value);
      logic [12:0] low_bits;
      low_bits = value[12:0];
      if (low_bits < DIM_LOW) begin
         return DIM_LOW;
      end else if (low_bits > DIM_HIGH) begin
         return DIM_HIGH;
      end
      return low_bits;
   endfunction

   // Register writes on the access phase.
   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite && pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (cfg_write) begin
         unique case (paddr[4:2])
            REG_FRAME_WIDTH:  cfg_in.frame_width  = clamp_dim(pwdata);
            REG_FRAME_HEIGHT: cfg_in.frame_height = clamp_dim(pwdata);
            REG_PIXEL_MODE:   cfg_in.pixel_mode   = pwdata[0];
            REG_LINE_BYTES:   cfg_in.line_bytes   = pwdata[14:0];
            REG_FRAME_BASE:   cfg_in.frame_base   = pwdata;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_width  <= 13'd640;
         cfg_ff.frame_height <= 13'd480;
         cfg_ff.pixel_mode   <= 1'b0;
         cfg_ff.line_bytes   <= 15'd2560;
         cfg_ff.frame_base   <= 32'd0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Register read-back.
   always_comb begin
      unique case (paddr[4:2])
         REG_FRAME_WIDTH:  prdata = {19'b0, cfg_ff.frame_width};
         REG_FRAME_HEIGHT: prdata = {19'b0, cfg_ff.frame_height};
         REG_PIXEL_MODE:   prdata = {31'b0, cfg_ff.pixel_mode};
         REG_LINE_BYTES:   prdata = {17'b0, cfg_ff.line_bytes};
         REG_FRAME_BASE:   prdata = cfg_ff.frame_base;
         default:          prdata = '0;
      endcase
   end

   tppg_front u_front (
      .cfg         (cfg_ff),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .queue_full  (queue_full),
      .push        (queue_push),
      .push_data   (push_data)
   );

   tppg_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (queue_push),
      .push_data  (push_data),
      .full       (queue_full),
      .pop        (queue_pop),
      .head_valid (head_valid),
      .head_data  (head_data)
   );

   tppg_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .head_valid  (head_valid),
      .head_data   (head_data),
      .pop         (queue_pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   // An off-frame pixel never carries a word or an address.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.in_range |->
         rsp_payload.pixel_word == '0 && rsp_payload.write_address == '0)
      else $error("off-frame response carries data");

   // Frame dimensions stay inside the clamped range.
   assert property (@(posedge clock) disable iff (reset)
      cfg_ff.frame_width >= DIM_LOW && cfg_ff.frame_width <= DIM_HIGH
      && cfg_ff.frame_height >= DIM_LOW && cfg_ff.frame_height <= DIM_HIGH)
      else $error("frame dimension out of range");

   // A response appears only for an item that went through the queue.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(head_valid))
      else $error("response without a queued item");

   // Back pressure reaches the request side only through a full queue.
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> queue_full && !queue_push)
      else $error("request stalled with room in the queue");

endmodule

// ===== sv/tppg_front.sv =====
// Front end: takes request transfers, classifies the pixel and computes the row offset.
`timescale 1ns / 1ps
module tppg_front (
   input  tppg_pkg::cfg_type   cfg,
   input  logic                req_valid,
   output logic                req_ready,
   input  tppg_pkg::req_type   req_payload,
   input  logic                queue_full,
   output logic                push,
   output tppg_pkg::entry_type push_data
);
   import tppg_pkg::*;

   localparam logic [12:0] BORDER = 13'(BORDER_PIXELS);

   logic [12:0] x13;
   logic [12:0] y13;
   logic [12:0] right_edge;
   logic [12:0] bottom_edge;
   logic [12:0] dist_right;
   logic [12:0] dist_bottom;
   logic [13:0] x_times3;
   logic [13:0] width_times2;
   logic        mid_x;
   logic        mid_y;
   logic        frame_line;
   logic        diag_main;
   logic        diag_anti;
   logic        ramp_first;
   logic        ramp_second;
   color_class_type pixel_class;

   // Accept whenever the queue has room.
   assign req_ready = !queue_full;
   assign push      = req_valid && !queue_full;

   // Geometry relative to the frame edges; all in range once the pixel is inside.
   assign x13         = {1'b0, req_payload.pixel_x};
   assign y13         = {1'b0, req_payload.pixel_y};
   assign right_edge  = cfg.frame_width - BORDER;
   assign bottom_edge = cfg.frame_height - BORDER;
   assign dist_right  = cfg.frame_width - x13;
   assign dist_bottom = cfg.frame_height - y13;

   assign mid_x      = (x13 > BORDER) && (x13 < right_edge);
   assign mid_y      = (y13 > BORDER) && (y13 < bottom_edge);
   assign frame_line = (x13 == BORDER) || (x13 == right_edge)
                    || (y13 == BORDER) || (y13 == bottom_edge);
   assign diag_main  = (x13 == y13) || (dist_right == dist_bottom);
   assign diag_anti  = (dist_right == y13) || (x13 == dist_bottom);

   // Ramp band floor(3x/w) found by comparing 3x with w and 2w.
   assign x_times3     = {x13, 1'b0} + {1'b0, x13};
   assign width_times2 = {cfg.frame_width, 1'b0};
   assign ramp_first   = x_times3 < {1'b0, cfg.frame_width};
   assign ramp_second  = x_times3 < width_times2;

   // Pattern priority, first match wins.
   always_comb begin
      if ((x13 < BORDER) && (y13 < BORDER)) begin
         pixel_class = CLASS_WHITE;
      end else if ((x13 < BORDER) && mid_y) begin
         pixel_class = CLASS_BLUE;
      end else if ((y13 < BORDER) && mid_x) begin
         pixel_class = CLASS_GREEN;
      end else if ((x13 > right_edge) && mid_y) begin
         pixel_class = CLASS_RED;
      end else if ((y13 > bottom_edge) && mid_x) begin
         pixel_class = CLASS_YELLOW;
      end else if (frame_line) begin
         pixel_class = CLASS_WHITE;
      end else if (diag_main) begin
         pixel_class = CLASS_MAGENTA;
      end else if (diag_anti) begin
         pixel_class = CLASS_CYAN;
      end else if (mid_x && mid_y) begin
         if (ramp_first) begin
            pixel_class = CLASS_RAMP_BLUE;
         end else if (ramp_second) begin
            pixel_class = CLASS_RAMP_GREEN;
         end else begin
            pixel_class = CLASS_RAMP_RED;
         end
      end else begin
         pixel_class = CLASS_BLACK;
      end
   end

   // Queue entry; the row offset product is registered by the queue.
   always_comb begin
      push_data.color_class = pixel_class;
      push_data.ramp_level  = req_payload.pixel_y[7:0];
      push_data.pixel_x     = req_payload.pixel_x;
      push_data.row_offset  = 27'(cfg.line_bytes) * 27'(req_payload.pixel_y);
      push_data.in_range    = (x13 < cfg.frame_width) && (y13 < cfg.frame_height);
   end

endmodule

// ===== sv/tppg_queue.sv =====
// Short queue of classified pixels between the front end and the back end.
`timescale 1ns / 1ps
module tppg_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  tppg_pkg::entry_type push_data,
   output logic                full,
   input  logic                pop,
   output logic                head_valid,
   output tppg_pkg::entry_type head_data
);
   import tppg_pkg::*;

   localparam int unsigned PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned COUNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0]   LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(QUEUE_DEPTH);

   entry_type          slots_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [PTR_W-1:0]   wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [PTR_W-1:0]   rd_ptr_in;
   logic [COUNT_W-1:0] count_ff;
   logic [COUNT_W-1:0] count_in;
   logic               do_push;
   logic               do_pop;

   assign full       = (count_ff == FULL_COUNT);
   assign head_valid = (count_ff != '0);
   assign head_data  = slots_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage needs no reset; the fill count guards it.
   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== sv/tppg_back.sv =====
// Back end: turns a classified pixel into the stored word and its address.
`timescale 1ns / 1ps
module tppg_back (
   input  logic                clock,
   input  logic                reset,
   input  tppg_pkg::cfg_type   cfg,
   input  logic                head_valid,
   input  tppg_pkg::entry_type head_data,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output tppg_pkg::rsp_type   rsp_payload
);
   import tppg_pkg::*;

   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   rsp_type     rsp_payload_ff;
   rsp_type     rsp_payload_in;
   logic [23:0] color;
   logic [7:0]  ramp_5bit;
   logic [7:0]  ramp_6bit;
   logic [7:0]  ramp_blue_red;
   logic [7:0]  ramp_green;
   logic [23:0] packed_word;
   logic [31:0] column_offset;

   // The output register frees up when empty or when its transfer completes.
   assign pop = head_valid && (!rsp_valid_ff || rsp_ready);

   // Ramp levels: in 16-bit mode already at RGB565 field scale.
   assign ramp_5bit     = {head_data.ramp_level[4:0], 3'b000};
   assign ramp_6bit     = {head_data.ramp_level[5:0], 2'b00};
   assign ramp_blue_red = cfg.pixel_mode ? ramp_5bit : head_data.ramp_level;
   assign ramp_green    = cfg.pixel_mode ? ramp_6bit : head_data.ramp_level;

   // Color of each pattern class.
   always_comb begin
      unique case (head_data.color_class)
         CLASS_WHITE:      color = COLOR_WHITE;
         CLASS_BLUE:       color = COLOR_BLUE;
         CLASS_GREEN:      color = COLOR_GREEN;
         CLASS_RED:        color = COLOR_RED;
         CLASS_YELLOW:     color = COLOR_YELLOW;
         CLASS_MAGENTA:    color = COLOR_MAGENTA;
         CLASS_CYAN:       color = COLOR_CYAN;
         CLASS_RAMP_BLUE:  color = {16'h0000, ramp_blue_red};
         CLASS_RAMP_GREEN: color = {8'h00, ramp_green, 8'h00};
         CLASS_RAMP_RED:   color = {ramp_blue_red, 16'h0000};
         default:          color = COLOR_BLACK;
      endcase
   end

   // RGB565 packing and the column part of the address.
   assign packed_word   = {8'h00, color[23:19], color[15:10], color[7:3]};
   assign column_offset = cfg.pixel_mode ? {19'b0, head_data.pixel_x, 1'b0}
                                         : {18'b0, head_data.pixel_x, 2'b00};

   // Next output register contents.
   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_payload_in = rsp_payload_ff;
      if (pop) begin
         rsp_valid_in = 1'b1;
         if (head_data.in_range) begin
            rsp_payload_in.pixel_word    = cfg.pixel_mode ? packed_word : color;
            rsp_payload_in.write_address = cfg.frame_base
                                         + {5'b0, head_data.row_offset}
                                         + column_offset;
            rsp_payload_in.in_range      = 1'b1;
         end else begin
            rsp_payload_in.pixel_word    = '0;
            rsp_payload_in.write_address = '0;
            rsp_payload_in.in_range      = 1'b0;
         end
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

// ===== dv/tb_test_pattern_pixel_generator.sv =====
// Self-checking testbench for the test pattern pixel generator: random pixels across many frame setups.
`timescale 1ns / 1ps
module tb_test_pattern_pixel_generator;

   import tppg_pkg::*;

   localparam int LONG_HOLD_CYCLES = 400;
   localparam int WATCHDOG_LIMIT   = 4000;
   localparam int ITEMS_PER_PHASE  = 125;
   localparam int PHASES           = 9;
   localparam int DIRECTED         = 24;

   // Expected pattern words and addresses, computed from a private copy of the registers.
   class pixel_checker;
      int unsigned       frame_width;
      int unsigned       frame_height;
      bit                pixel_mode;
      int unsigned       line_bytes;
      logic [31:0]       frame_base;
      rsp_type           pending_pixels[$];
      int unsigned       mismatches;
      int unsigned       pixels_noted;
      int unsigned       in_frame_noted;
      int unsigned       results_seen;

      function new();
         frame_width    = 640;
         frame_height   = 480;
         pixel_mode     = 1'b0;
         line_bytes     = 2560;
         frame_base     = 32'h0;
         mismatches     = 0;
         pixels_noted   = 0;
         in_frame_noted = 0;
         results_seen   = 0;
      endfunction

      // Frame sizes saturate into the legal range on a write.
      function int unsigned clamp_dimension(logic [12:0] value);
         if (value < MIN_DIMENSION) return MIN_DIMENSION;
         if (value > MAX_DIMENSION) return MAX_DIMENSION;
         return value;
      endfunction

      function void apply_register(logic [2:0] index, logic [31:0] value);
         case (index)
            REG_FRAME_WIDTH: begin
               frame_width = clamp_dimension(value[12:0]);
            end
            REG_FRAME_HEIGHT: begin
               frame_height = clamp_dimension(value[12:0]);
            end
            REG_PIXEL_MODE: begin
               pixel_mode = value[0];
            end
            REG_LINE_BYTES: begin
               line_bytes = value[14:0];
            end
            REG_FRAME_BASE: begin
               frame_base = value;
            end
            default: begin
            end
         endcase
      endfunction

      // Pattern color, packing and address of one pixel.
      function rsp_type pattern_pixel(logic [11:0] x_in, logic [11:0] y_in);
         rsp_type     res;
         int          x, y, w, h, b, band, level;
         bit          mid_x, mid_y;
         logic [23:0] color;
         logic [31:0] addr;
         x = x_in;
         y = y_in;
         w = frame_width;
         h = frame_height;
         b = BORDER_PIXELS;
         res = '0;
         if (x >= w || y >= h) return res;

         mid_x = (x > b) && (x < w - b);
         mid_y = (y > b) && (y < h - b);
         if (x < b && y < b) color = COLOR_WHITE;
         else if (x < b && mid_y) color = COLOR_BLUE;
         else if (y < b && mid_x) color = COLOR_GREEN;
         else if (x > w - b && mid_y) color = COLOR_RED;
         else if (y > h - b && mid_x) color = COLOR_YELLOW;
         else if (x == b || x == w - b || y == b || y == h - b) color = COLOR_WHITE;
         else if (x == y || w - x == h - y) color = COLOR_MAGENTA;
         else if (w - x == y || x == h - y) color = COLOR_CYAN;
         else if (mid_x && mid_y) begin
            // Three vertical bands; the level follows the row, in 16-bit mode scaled to the 565 fields.
            band = (x * 3) / w;
            if (!pixel_mode) level = y % 256;
            else if (band == 1) level = (y % 64) * 4;
            else level = (y % 32) * 8;
            color = COLOR_BLACK;
            if (band == 0) color[7:0] = 8'(level);
            else if (band == 1) color[15:8] = 8'(level);
            else color[23:16] = 8'(level);
         end else begin
            color = COLOR_BLACK;
         end

         addr = frame_base + 32'(line_bytes) * 32'(y);
         if (pixel_mode) begin
            res.pixel_word = {8'h00, color[23:19], color[15:10], color[7:3]};
            addr = addr + 32'(x) * 32'd2;
         end else begin
            res.pixel_word = color;
            addr = addr + 32'(x) * 32'd4;
         end
         res.write_address = addr;
         res.in_range = 1'b1;
         return res;
      endfunction

      function void note_pixel(req_type req);
         rsp_type want;
         want = pattern_pixel(req.pixel_x, req.pixel_y);
         pending_pixels.push_back(want);
         pixels_noted++;
         if (want.in_range) in_frame_noted++;
      endfunction

      function void report_mismatch(string what, rsp_type want, rsp_type got);
         mismatches++;
         if (mismatches <= 10) begin
            $display("%0t: %s: expected word %h addr %h in_range %b, got word %h addr %h in_range %b",
                     $realtime, what, want.pixel_word, want.write_address, want.in_range,
                     got.pixel_word, got.write_address, got.in_range);
         end
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         results_seen++;
         if (pending_pixels.size() == 0) begin
            report_mismatch("response with no request outstanding", '0, got);
            return;
         end
         want = pending_pixels.pop_front();
         if (got.pixel_word !== want.pixel_word || got.write_address !== want.write_address ||
             got.in_range !== want.in_range) begin
            report_mismatch("response mismatch", want, got);
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_payload = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_payload;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [4:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   pixel_checker chk = new();
   bit           sender_idles = 1'b1;
   logic         receiver_idles = 1'b1;
   int unsigned  hold_requests = 0;
   int unsigned  stall_cycles = 0;

   test_pattern_pixel_generator uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready)
   );

   always #10 clock = ~clock;

   // Offer one pixel and return at the edge of its transfer.
   task automatic send_pixel(input logic [11:0] x, input logic [11:0] y);
      req_type req;
      req.pixel_x = x;
      req.pixel_y = y;
      if (sender_idles && $urandom_range(99) < 27) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_payload <= req;
      req_valid   <= 1'b1;
      do @(posedge clock); while (!(req_valid && req_ready));
      chk.note_pixel(req_payload);
   endtask

   // Stop offering and wait until every outstanding response has come back.
   task automatic drain_responses();
      req_valid <= 1'b0;
      do @(posedge clock); while (chk.pending_pixels.size() != 0);
   endtask

   // Register write: setup cycle, then access cycle until pready. The caller ends the
   // access by dropping psel once its last write is done.
   task automatic csr_write(input logic [2:0] index, input logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {index, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      chk.apply_register(index, value);
   endtask

   task automatic configure_frame(input logic [31:0] width, input logic [31:0] height,
                                  input logic [31:0] mode, input logic [31:0] line,
                                  input logic [31:0] base);
      csr_write(REG_FRAME_WIDTH, width);
      csr_write(REG_FRAME_HEIGHT, height);
      csr_write(REG_PIXEL_MODE, mode);
      csr_write(REG_LINE_BYTES, line);
      csr_write(REG_FRAME_BASE, base);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // A coordinate on or next to a band edge or the frame edge, or inside the first border band.
   function automatic int near_boundary(int size);
      int b;
      b = BORDER_PIXELS;
      case ($urandom_range(4))
         0: return b - 1 + $urandom_range(2);
         1: return size - b - 1 + $urandom_range(2);
         2: return size - 1;
         3: return size;
         default: return $urandom_range(b - 1);
      endcase
   endfunction

   // Mostly in-frame pixels, biased toward band edges and diagonals.
   function automatic void pick_pixel(output logic [11:0] px, output logic [11:0] py);
      int w, h, x, y, r;
      w = chk.frame_width;
      h = chk.frame_height;
      r = $urandom_range(99);
      x = $urandom_range(w - 1);
      y = $urandom_range(h - 1);
      if (r < 15) begin
         x = $urandom_range(4095);
         y = $urandom_range(4095);
      end else if (r < 30) x = near_boundary(w);
      else if (r < 40) y = near_boundary(h);
      else if (r < 48) y = x;
      else if (r < 55) y = h - (w - x);
      else if (r < 61) y = w - x;
      else if (r < 67) y = h - x;
      // Diagonal picks that miss the frame fall back to a plain interior row.
      if (r >= 40 && (y < 0 || y >= h)) y = $urandom_range(h - 1);
      px = (x > 4095) ? 12'd4095 : 12'(x);
      py = (y > 4095) ? 12'd4095 : 12'(y);
   endfunction

   // Receiver: random back-pressure plus one long hold-off on request.
   initial begin : receiver
      int          hold_left;
      int unsigned holds_taken;
      hold_left = 0;
      holds_taken = 0;
      forever begin
         @(posedge clock);
         if (holds_taken != hold_requests) begin
            holds_taken = hold_requests;
            hold_left = LONG_HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (receiver_idles && $urandom_range(99) < 27) begin
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Every response transfer is checked against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) chk.check_result(rsp_payload);
   end

   // Watchdog: too long without any transfer ends the run.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || psel) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("test_pattern_pixel_generator regression: fail");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin : stimulus
      // Corners, bands, frame lines, diagonals, ramps, black areas and off-frame pixels
      // of the default 640 x 480 frame.
      int unsigned directed_x [DIRECTED] = '{0, 19, 4095, 640, 0, 639, 5, 100, 630, 100,
                                             20, 620, 100, 100, 50, 300, 400, 100, 100,
                                             300, 500, 635, 10, 2730};
      int unsigned directed_y [DIRECTED] = '{0, 19, 4095, 0, 480, 479, 100, 5, 100, 470,
                                             100, 100, 20, 460, 50, 140, 240, 380, 300,
                                             301, 333, 470, 470, 1365};
      logic [11:0] x, y;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIRECTED; i++) begin
         send_pixel(12'(directed_x[i]), 12'(directed_y[i]));
      end

      for (int phase = 0; phase < PHASES; phase++) begin
         drain_responses();
         case (phase)
            0: ;
            // Smallest frame from an under-range write, 16-bit pixels, address wrap.
            1: configure_frame(32'd0, 32'd5, 32'd1, 32'd0, 32'hffff_fff0);
            // Largest frame from over-range writes, widest line pitch.
            2: configure_frame(32'd8191, 32'd4097, 32'd0, 32'h7fff, 32'hffff_ffff);
            // Upper bits beyond the register width are dropped.
            3: configure_frame(32'hffff_0029, 32'd4096, 32'hffff_fffe, 32'hffff_4000,
                               $urandom);
            default: configure_frame($urandom_range(8191), $urandom_range(30, 4200),
                                     $urandom_range(1), $urandom_range(32767), $urandom);
         endcase

         // Phase 2 stalls the receiver long enough to fill the block; phase 4 runs flat out.
         sender_idles = (phase != 4);
         receiver_idles <= (phase != 4);
         if (phase == 2) hold_requests <= hold_requests + 1;

         for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
            pick_pixel(x, y);
            send_pixel(x, y);
         end
      end

      drain_responses();
      repeat (10) @(posedge clock);

      $display("Sent %0d pixels (%0d inside the frame) over %0d register settings,",
               chk.pixels_noted, chk.in_frame_noted, PHASES);
      $display("from 41 x 41 to 4096 x 4096 in both pixel modes; %0d responses checked.",
               chk.results_seen);
      if (chk.mismatches == 0 && chk.pending_pixels.size() == 0) begin
         $display("test_pattern_pixel_generator regression: pass");
      end else begin
         $display("%0d mismatches, %0d responses missing", chk.mismatches,
                  chk.pending_pixels.size());
         $display("test_pattern_pixel_generator regression: fail");
      end
      $finish;
   end

endmodule
